### rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Empty bodies when SYNTH is set.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/nfp_pkg.sv
// -----------------------------------------------------------------------------
// nfp_pkg
// Shared types and character codes of the NMEA field number parser.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfp_pkg;

  localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
  localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CH_POINT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_COMMA   = 8'h2C;  // ','
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'

  localparam logic [2:0] FRAC_DIGITS_RESET = 3'd5;

  localparam int unsigned FIELD_NUM_W = 5;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned FRAC_W      = 3;

  typedef struct packed {
    logic [FIELD_NUM_W-1:0]    field_number;
    logic signed [VALUE_W-1:0] field_value;
    logic [FRAC_W-1:0]         fraction_count;
    logic                      field_bad;
    logic                      sentence_end;
  } result_t;

endpackage

### rtl/core/nfp_field_core.sv
// -----------------------------------------------------------------------------
// nfp_field_core
// Per-field parse state; decodes one character and forms the field result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfp_field_core #(
  parameter int unsigned MAX_FIELD_NUMBER = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       char_in,
  input  logic [2:0]       max_frac,
  output logic             emit,
  output nfp_pkg::result_t result
);
  import nfp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FIELD_NUMBER + 1);

  logic [CW-1:0]      field_count;
  logic [VALUE_W-1:0] accumulator;
  logic [FRAC_W-1:0]  kept_fraction;
  logic               after_point;
  logic               is_negative;
  logic               is_bad;
  logic               at_field_start;

  logic               is_term;
  logic               is_comma;
  logic               is_digit;
  logic [VALUE_W-1:0] acc_mac;

  assign is_term  = (char_in == CH_STAR) || !(char_in inside {[CH_SPACE:CH_LOWER_Z]});
  assign is_comma = (char_in == CH_COMMA);
  assign is_digit = char_in inside {[CH_ZERO:CH_NINE]};
  assign emit     = is_term || is_comma;

  // times ten as two shifts, plus the digit
  assign acc_mac = (accumulator << 3) + (accumulator << 1)
                 + {{(VALUE_W-4){1'b0}}, char_in[3:0]};

  always_comb begin
    result.field_number   = FIELD_NUM_W'(field_count);
    result.field_value    = '0;
    result.fraction_count = '0;
    result.field_bad      = is_bad;
    result.sentence_end   = is_term;
    if (!is_bad) begin
      result.field_value    = is_negative ? (VALUE_W'(0) - accumulator) : accumulator;
      result.fraction_count = kept_fraction;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count    <= '0;
      accumulator    <= '0;
      kept_fraction  <= '0;
      after_point    <= 1'b0;
      is_negative    <= 1'b0;
      is_bad         <= 1'b0;
      at_field_start <= 1'b1;
    end else if (step) begin
      if (emit) begin
        if (is_term) begin
          field_count <= '0;
        end else if (field_count < CW'(MAX_FIELD_NUMBER)) begin
          field_count <= field_count + CW'(1);
        end
        accumulator    <= '0;
        kept_fraction  <= '0;
        after_point    <= 1'b0;
        is_negative    <= 1'b0;
        is_bad         <= 1'b0;
        at_field_start <= 1'b1;
      end else if (!is_bad) begin
        if (char_in == CH_MINUS && at_field_start) begin
          is_negative <= 1'b1;
        end else if (char_in == CH_POINT && !after_point) begin
          after_point <= 1'b1;
        end else if (is_digit) begin
          if (!after_point) begin
            accumulator <= acc_mac;
          end else if (kept_fraction < max_frac) begin
            accumulator   <= acc_mac;
            kept_fraction <= kept_fraction + FRAC_W'(1);
          end
        end else begin
          is_bad <= 1'b1;
        end
        at_field_start <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/nmea_field_number_parser.sv
// -----------------------------------------------------------------------------
// nmea_field_number_parser
// Streams sentence characters in and emits one scaled number per field.
// -----------------------------------------------------------------------------
//
//  channel  dir  handshake                  payload
//  -------  ---  -------------------------  ---------------------------------
//  s_*      in   s_tvalid / s_tready        s_tdata: char_in
//  m_*      out  m_tvalid / m_tready        m_tdata, m_tuser, m_tlast
//  cfg_*    in   cfg_valid / cfg_ready      cfg_data: max_fraction_digits
//
//  One character per clock, unless a stalled output holds an emitting character.
//  A character is held in the input register, then the field core decodes it and
//  updates its state; a comma or terminator loads the output register at that
//  edge, which raises m_tvalid. The multiply-by-ten-and-add of the accumulator
//  sets the cycle path.
//  Reset clears all control state and sets max_fraction_digits to 5; no clearing
//  pass. A stalled output only blocks a character that would emit a result;
//  digits, points and minus signs keep flowing. cfg_ready is always high.
//
`timescale 1ns / 1ps

module nmea_field_number_parser #(
  parameter int unsigned MAX_FIELD_NUMBER = 31
) (
  input  logic        clk,
  input  logic        rst,
  // input characters
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] char_in
  // field results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [4:0] field_number, [36:5] field_value,
                                  // [39:37] fraction_count
  output logic [0:0]  m_tuser,    // [0] field_bad
  output logic        m_tlast,    // sentence_end
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [2:0] max_fraction_digits
);
  import nfp_pkg::*;

  logic       in_vld;
  logic [7:0] in_char;
  logic [2:0] max_frac;
  logic       emit;
  logic       advance;
  result_t    core_res;
  result_t    out_res;

  assign cfg_ready = 1'b1;

  // hold the configured fraction limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frac <= FRAC_DIGITS_RESET;
    end else if (cfg_valid) begin
      max_frac <= cfg_data[2:0];
    end
  end

  // advance the held character unless it emits into a full, stalled output
  assign advance  = in_vld && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  nfp_field_core #(
    .MAX_FIELD_NUMBER (MAX_FIELD_NUMBER)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .char_in  (in_char),
    .max_frac (max_frac),
    .emit     (emit),
    .result   (core_res)
  );

  // output register: load on an emitting step, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {out_res.fraction_count, out_res.field_value, out_res.field_number};
  assign m_tuser = out_res.field_bad;
  assign m_tlast = out_res.sentence_end;

`include "assert_macros.svh"

  // input side stalls only behind a held emitting character and a stalled output
  `ASSERT_IMP(a_stall_cause, clk, rst, !s_tready, in_vld && emit && m_tvalid && !m_tready)
  // a bad field never carries a value or fraction count
  `ASSERT_IMP(a_bad_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata[39:5] == 35'd0)
  // a terminator result is followed by field zero of the next sentence
  `ASSERT_NEXT(a_term_restart, clk, rst, advance && emit && core_res.sentence_end, core_res.field_number == 5'd0)

endmodule
